FILE: hdl/next_fit_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the next-fit heap allocator
// Shorthand for clocked implication checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define NFHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/nfha_pkg.sv
// ----------------------------------------------------------------------------
// nfha_pkg
// Types and constants shared by the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

    localparam int ARENA_GRANULES    = 65536;
    localparam int GRANULE_BYTES     = 16;
    localparam int HEADER_GRANULES   = 2;
    localparam int PREFIX_GRANULES   = 1;
    localparam int MIN_PAYLOAD_BYTES = 32;

    localparam int GIDX_W = $clog2(ARENA_GRANULES);
    localparam int GCNT_W = GIDX_W + 1;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 21;
    localparam int ALIGN_W = 17;
    localparam int GSH    = $clog2(GRANULE_BYTES);
    localparam int AG_W   = ALIGN_W - GSH;
    localparam int LOG_W  = ADDR_W - GSH;

    // smallest block, in granules
    localparam int MIN_BLOCK_G = HEADER_GRANULES + PREFIX_GRANULES
                               + MIN_PAYLOAD_BYTES / GRANULE_BYTES;
    // user pointer sits this far past the block start before alignment
    localparam int USER_OFS_G  = HEADER_GRANULES + PREFIX_GRANULES;

    localparam logic REG_ARENA_BASE   = 1'b0;
    localparam logic REG_ARENA_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADADDR = 2'd2
    } t_status;

    typedef struct packed {
        t_mode               mode;
        logic [SIZE_W-1:0]   req_size;
        logic [ALIGN_W-1:0]  req_alignment;
        logic [ADDR_W-1:0]   address;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   result_address;
        logic [SIZE_W-1:0]   result_size;
    } t_result;

    typedef struct packed {
        logic                start;
        logic                free;
        logic [GCNT_W-1:0]   span;
        logic [GIDX_W-1:0]   prev;
    } t_meta;

    typedef struct packed {
        logic                mark;
        logic [SIZE_W-1:0]   size;
        logic [GIDX_W-1:0]   blk;
    } t_grant;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT_CHK,
        S_CLR,
        S_A_RD,
        S_A_E1,
        S_A_E2,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_G_CHK,
        S_G_CHK2,
        S_F_N1,
        S_F_ABS,
        S_F_N2,
        S_F_WB,
        S_F_P1,
        S_RESP
    } t_state;

endpackage

FILE: hdl/next_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// Next-fit allocator with coalescing over a 16-byte-granule arena.
// ----------------------------------------------------------------------------
// Usage:
//  - Configure arena_base (0x0) and arena_length (0x4) over the APB port
//    while the block is idle; pready is always high, reads return the values.
//  - Issue an item with start while busy is low: mode init, allocate, free or
//    query. Exactly one result comes back, shown for one cycle with
//    o_result_valid; the receiver cannot stall, so it must take it then.
//  - Allocate does one metadata read plus two evaluation steps for each block
//    visited on the next-fit walk, then the split and the response.
//  - Init clears the metadata of every granule of the new arena, one granule a cycle.
//  - The walk is paced by the single-port-per-direction metadata RAMs: each
//    step of the walk waits for one registered read.
//  - After reset the arena is not ready: allocate answers no-space, free and
//    query answer bad-address until an init succeeds. The RAMs are not
//    cleared by reset; init does that.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  nfha_pkg::t_cmd              i_cmd,
    output logic                        o_result_valid,
    output nfha_pkg::t_result           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import nfha_pkg::*;

    // ---------------------------------------------------------------- state
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_len;
    logic [LOG_W-1:0]    r_lo_g, n_lo_g;       // arena start in granules
    logic [GCNT_W-1:0]   r_gcnt, n_gcnt;       // arena size in granules
    logic                r_ready, n_ready;
    logic [GIDX_W-1:0]   r_cursor, n_cursor;   // next-fit search start

    // working registers
    logic [GCNT_W-1:0]   r_cnt, n_cnt;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [GCNT_W:0]     r_szg, n_szg;         // request in granules
    logic [AG_W-1:0]     r_amask, n_amask;     // alignment mask in granules
    logic [GIDX_W-1:0]   r_b, n_b;             // current block
    logic [GIDX_W-1:0]   r_start, n_start;
    logic                r_wrapped, n_wrapped;
    logic [GCNT_W-1:0]   r_spanb, n_spanb;
    logic [GIDX_W-1:0]   r_prevb, n_prevb;
    logic                r_bfree, n_bfree;
    logic [GCNT_W-1:0]   r_endg, n_endg;
    logic [LOG_W:0]      r_u, n_u;             // aligned user granule, absolute
    logic [LOG_W:0]      r_lim, n_lim;         // block end granule, absolute
    logic [GIDX_W-1:0]   r_ug, n_ug;
    logic [GCNT_W-1:0]   r_sg, n_sg;
    logic                r_split, n_split;
    logic [GIDX_W-1:0]   r_g, n_g;
    logic [SIZE_W-1:0]   r_gsize, n_gsize;
    logic [GIDX_W-1:0]   r_n, n_n;
    logic [GCNT_W-1:0]   r_nspan, n_nspan;
    logic [GIDX_W-1:0]   r_after, n_after;
    logic                r_phase, n_phase;
    logic                r_query, n_query;
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_raddr, n_raddr;
    logic [SIZE_W-1:0]   r_rsize, n_rsize;

    // ---------------------------------------------------------------- RAMs
    logic                meta_we, meta_re, grant_we, grant_re;
    logic [GIDX_W-1:0]   meta_waddr, meta_raddr, grant_waddr, grant_raddr;
    t_meta               meta_wdata, meta_rdata;
    t_grant              grant_wdata, grant_rdata;

    // per-granule block metadata
    nfha_ram #(.WIDTH($bits(t_meta)), .DEPTH(ARENA_GRANULES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    // per-granule grant records, indexed by user pointer
    nfha_ram #(.WIDTH($bits(t_grant)), .DEPTH(ARENA_GRANULES)) u_grant (
        .i_clk   (i_clk),
        .i_we    (grant_we),
        .i_waddr (grant_waddr),
        .i_wdata (grant_wdata),
        .i_re    (grant_re),
        .i_raddr (grant_raddr),
        .o_rdata (grant_rdata)
    );

    // ------------------------------------------------------ config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ARENA_LENGTH) ? {{(32-SIZE_W){1'b0}}, r_len} : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_len  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_ARENA_BASE) begin
                r_base <= pwdata;
            end else begin
                r_len <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // ------------------------------------------------------ arena setup math
    logic [ADDR_W:0]     lo_sum, hi_sum;
    logic [LOG_W:0]      lo_g29, hi_g29, n_diff;
    logic [GCNT_W-1:0]   n_sat;
    logic                init_ok;

    always_comb begin
        lo_sum = {1'b0, r_base} + (ADDR_W+1)'(GRANULE_BYTES - 1);
        hi_sum = {1'b0, r_base} + (ADDR_W+1)'(r_len);
        lo_g29 = lo_sum[ADDR_W:GSH];
        hi_g29 = hi_sum[ADDR_W:GSH];
        n_diff = hi_g29 - lo_g29;
        n_sat  = (n_diff > (LOG_W+1)'(ARENA_GRANULES)) ? GCNT_W'(ARENA_GRANULES)
                                                        : n_diff[GCNT_W-1:0];
        // end must stay inside 4 GiB, arena must hold one minimal block
        init_ok = (hi_g29 <= {1'b1, {LOG_W{1'b0}}}) && (hi_g29 > lo_g29)
               && (n_sat >= GCNT_W'(MIN_BLOCK_G));
    end

    // ------------------------------------------------------ request decode
    logic [ALIGN_W-1:0]  al_raised;
    logic                al_ok;
    logic [SIZE_W-1:0]   sz_adj;
    logic [SIZE_W:0]     sz_round;
    logic [LOG_W:0]      a_diff;
    logic                addr_ok;

    always_comb begin
        al_raised = (i_cmd.req_alignment < ALIGN_W'(16)) ? ALIGN_W'(16) : i_cmd.req_alignment;
        al_ok     = ((al_raised & (al_raised - ALIGN_W'(1))) == '0);
        sz_adj    = (i_cmd.req_size == '0) ? SIZE_W'(1) : i_cmd.req_size;
        sz_round  = {1'b0, sz_adj} + (SIZE_W+1)'(GRANULE_BYTES - 1);
        // pointer offset from arena start, in granules
        a_diff    = {1'b0, i_cmd.address[ADDR_W-1:GSH]} - {1'b0, r_lo_g};
        addr_ok   = r_ready && (i_cmd.address != '0) && (i_cmd.address[GSH-1:0] == '0)
                 && !a_diff[LOG_W] && (a_diff[LOG_W-1:0] >= LOG_W'(PREFIX_GRANULES))
                 && (a_diff[LOG_W-1:0] < LOG_W'(r_gcnt));
    end

    // ------------------------------------------------------ walk arithmetic
    logic [LOG_W:0]      x_abs, u_abs, amask_ext;
    logic [GCNT_W-1:0]   endg_now;
    logic                fits;
    logic [LOG_W:0]      ug_full;
    logic [GCNT_W+1:0]   sg_full;
    logic [GCNT_W-1:0]   adv;
    logic                adv_wrap;
    logic [GIDX_W-1:0]   adv_b;
    logic [GCNT_W-1:0]   nx;
    logic [GCNT_W-1:0]   n_end;
    logic [GCNT_W-1:0]   after_full;

    always_comb begin
        amask_ext = (LOG_W+1)'(r_amask);
        endg_now  = GCNT_W'(r_b) + meta_rdata.span;
        x_abs     = {1'b0, r_lo_g} + (LOG_W+1)'(r_b) + (LOG_W+1)'(USER_OFS_G);
        u_abs     = (x_abs + amask_ext) & ~amask_ext;
        fits      = r_bfree && (({1'b0, r_u} + (LOG_W+2)'(r_szg)) <= {1'b0, r_lim});
        ug_full   = r_u - {1'b0, r_lo_g};
        sg_full   = (GCNT_W+2)'(ug_full[GIDX_W-1:0]) + (GCNT_W+2)'(r_szg);
        // next block on the walk, wrapping once to block zero
        adv       = r_endg;
        adv_wrap  = (adv >= r_gcnt);
        adv_b     = adv_wrap ? '0 : adv[GIDX_W-1:0];
        nx        = r_split ? r_sg : r_endg;
        n_end     = GCNT_W'(r_b) + meta_rdata.span;
        after_full = GCNT_W'(r_n) + r_nspan;
    end

    // ------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.mode)
                        MODE_INIT:  n_state = S_INIT_CHK;
                        MODE_ALLOC: n_state = (al_ok && r_ready) ? S_A_RD : S_RESP;
                        default:    n_state = addr_ok ? S_G_CHK : S_RESP;
                    endcase
                end
            end
            S_INIT_CHK: n_state = init_ok ? S_CLR : S_RESP;
            S_CLR:      n_state = (r_cnt == r_gcnt - GCNT_W'(1)) ? S_RESP : S_CLR;
            S_A_RD:     n_state = S_A_E1;
            S_A_E1:     n_state = S_A_E2;
            S_A_E2: begin
                if (fits) begin
                    n_state = S_A_W1;
                end else if (adv_wrap && r_wrapped) begin
                    n_state = S_RESP;
                end else if ((r_wrapped || adv_wrap) && adv_b == r_start) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_W1:     n_state = r_split ? S_A_W2 : S_RESP;
            S_A_W2:     n_state = (r_endg < r_gcnt) ? S_A_W3 : S_RESP;
            S_A_W3:     n_state = S_RESP;
            S_G_CHK:    n_state = grant_rdata.mark ? S_G_CHK2 : S_RESP;
            S_G_CHK2: begin
                if (!meta_rdata.start || meta_rdata.free || r_query) begin
                    n_state = S_RESP;
                end else begin
                    n_state = (n_end < r_gcnt) ? S_F_N1 : S_F_WB;
                end
            end
            S_F_N1:     n_state = meta_rdata.free ? S_F_ABS : S_F_WB;
            S_F_ABS:    n_state = (after_full < r_gcnt) ? S_F_N2 : S_F_WB;
            S_F_N2:     n_state = S_F_WB;
            S_F_WB:     n_state = (!r_phase && r_b != '0) ? S_F_P1 : S_RESP;
            S_F_P1: begin
                if (meta_rdata.start && meta_rdata.free
                    && (GCNT_W'(r_prevb) + meta_rdata.span == GCNT_W'(r_b))) begin
                    n_state = S_F_ABS;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------ datapath and RAM control
    always_comb begin
        meta_we     = 1'b0;
        meta_waddr  = r_b;
        meta_wdata  = '0;
        meta_re     = 1'b0;
        meta_raddr  = r_b;
        grant_we    = 1'b0;
        grant_waddr = r_g;
        grant_wdata = '0;
        grant_re    = 1'b0;
        grant_raddr = a_diff[GIDX_W-1:0];

        n_lo_g    = r_lo_g;
        n_gcnt    = r_gcnt;
        n_ready   = r_ready;
        n_cursor  = r_cursor;
        n_cnt     = r_cnt;
        n_size    = r_size;
        n_szg     = r_szg;
        n_amask   = r_amask;
        n_b       = r_b;
        n_start   = r_start;
        n_wrapped = r_wrapped;
        n_spanb   = r_spanb;
        n_prevb   = r_prevb;
        n_bfree   = r_bfree;
        n_endg    = r_endg;
        n_u       = r_u;
        n_lim     = r_lim;
        n_ug      = r_ug;
        n_sg      = r_sg;
        n_split   = r_split;
        n_g       = r_g;
        n_gsize   = r_gsize;
        n_n       = r_n;
        n_nspan   = r_nspan;
        n_after   = r_after;
        n_phase   = r_phase;
        n_query   = r_query;
        n_status  = r_status;
        n_raddr   = r_raddr;
        n_rsize   = r_rsize;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_raddr   = '0;
                    n_rsize   = '0;
                    n_size    = sz_adj;
                    n_szg     = sz_round[SIZE_W:GSH];
                    n_amask   = al_raised[ALIGN_W-1:GSH] - AG_W'(1);
                    n_b       = r_cursor;
                    n_start   = r_cursor;
                    n_wrapped = 1'b0;
                    n_g       = a_diff[GIDX_W-1:0];
                    n_query   = (i_cmd.mode == MODE_QUERY);
                    n_phase   = 1'b0;
                    case (i_cmd.mode)
                        MODE_INIT:  n_status = ST_OK;
                        MODE_ALLOC: n_status = (al_ok && r_ready) ? ST_OK : ST_NOSPACE;
                        default: begin
                            n_status = addr_ok ? ST_OK : ST_BADADDR;
                            grant_re = addr_ok;
                        end
                    endcase
                end
            end
            S_INIT_CHK: begin
                // old arena is dropped either way
                n_ready  = 1'b0;
                n_cursor = '0;
                n_cnt    = '0;
                if (init_ok) begin
                    n_lo_g = lo_g29[LOG_W-1:0];
                    n_gcnt = n_sat;
                end else begin
                    n_status = ST_NOSPACE;
                end
            end
            S_CLR: begin
                // clear each granule; granule zero becomes one free block
                meta_we     = 1'b1;
                meta_waddr  = r_cnt[GIDX_W-1:0];
                meta_wdata  = (r_cnt == '0) ? '{start: 1'b1, free: 1'b1, span: r_gcnt,
                                                prev: '0} : '0;
                grant_we    = 1'b1;
                grant_waddr = r_cnt[GIDX_W-1:0];
                grant_wdata = '0;
                n_cnt       = r_cnt + GCNT_W'(1);
                if (r_cnt == r_gcnt - GCNT_W'(1)) begin
                    n_ready = 1'b1;
                end
            end
            S_A_RD: begin
                meta_re    = 1'b1;
                meta_raddr = r_b;
            end
            S_A_E1: begin
                n_bfree = meta_rdata.free;
                n_spanb = meta_rdata.span;
                n_prevb = meta_rdata.prev;
                n_endg  = endg_now;
                n_u     = u_abs;
                n_lim   = {1'b0, r_lo_g} + (LOG_W+1)'(endg_now);
            end
            S_A_E2: begin
                if (fits) begin
                    n_ug    = ug_full[GIDX_W-1:0];
                    n_sg    = sg_full[GCNT_W-1:0];
                    n_split = ((r_endg - sg_full[GCNT_W-1:0]) >= GCNT_W'(MIN_BLOCK_G));
                    n_raddr = {r_u[LOG_W-1:0], {GSH{1'b0}}};
                end else begin
                    n_b = adv_b;
                    if (adv_wrap) begin
                        n_wrapped = 1'b1;
                    end
                    if ((adv_wrap && r_wrapped)
                        || ((r_wrapped || adv_wrap) && adv_b == r_start)) begin
                        n_status = ST_NOSPACE;
                    end
                end
            end
            S_A_W1: begin
                grant_we    = 1'b1;
                grant_waddr = r_ug;
                grant_wdata = '{mark: 1'b1, size: r_size, blk: r_b};
                meta_we     = 1'b1;
                meta_waddr  = r_b;
                meta_wdata  = '{start: 1'b1, free: 1'b0,
                                span: r_split ? (r_sg - GCNT_W'(r_b)) : r_spanb,
                                prev: r_prevb};
                // fetch the block after the split tail to relink it
                meta_re     = r_split && (r_endg < r_gcnt);
                meta_raddr  = r_endg[GIDX_W-1:0];
                n_cursor    = (nx < r_gcnt) ? nx[GIDX_W-1:0] : '0;
            end
            S_A_W2: begin
                meta_we    = 1'b1;
                meta_waddr = r_sg[GIDX_W-1:0];
                meta_wdata = '{start: 1'b1, free: 1'b1, span: r_endg - r_sg, prev: r_b};
            end
            S_A_W3: begin
                meta_we    = 1'b1;
                meta_waddr = r_endg[GIDX_W-1:0];
                meta_wdata = '{start: meta_rdata.start, free: meta_rdata.free,
                               span: meta_rdata.span, prev: r_sg[GIDX_W-1:0]};
            end
            S_G_CHK: begin
                if (!grant_rdata.mark) begin
                    n_status = ST_BADADDR;
                end
                n_gsize    = grant_rdata.size;
                n_b        = grant_rdata.blk;
                meta_re    = grant_rdata.mark;
                meta_raddr = grant_rdata.blk;
            end
            S_G_CHK2: begin
                if (!meta_rdata.start || meta_rdata.free) begin
                    n_status = ST_BADADDR;
                end else if (r_query) begin
                    n_rsize = r_gsize;
                end else begin
                    grant_we    = 1'b1;
                    grant_waddr = r_g;
                    grant_wdata = '{mark: 1'b0, size: r_gsize, blk: r_b};
                    n_spanb     = meta_rdata.span;
                    n_prevb     = meta_rdata.prev;
                    n_n         = n_end[GIDX_W-1:0];
                    meta_re     = (n_end < r_gcnt);
                    meta_raddr  = n_end[GIDX_W-1:0];
                end
            end
            S_F_N1: begin
                n_nspan = meta_rdata.span;
            end
            S_F_ABS: begin
                // merge block r_n into r_b
                n_spanb    = r_spanb + r_nspan;
                meta_we    = 1'b1;
                meta_waddr = r_n;
                meta_wdata = '0;
                if (r_cursor == r_n) begin
                    n_cursor = r_b;
                end
                n_after    = after_full[GIDX_W-1:0];
                meta_re    = (after_full < r_gcnt);
                meta_raddr = after_full[GIDX_W-1:0];
            end
            S_F_N2: begin
                meta_we    = 1'b1;
                meta_waddr = r_after;
                meta_wdata = '{start: meta_rdata.start, free: meta_rdata.free,
                               span: meta_rdata.span, prev: r_b};
            end
            S_F_WB: begin
                meta_we    = 1'b1;
                meta_waddr = r_b;
                meta_wdata = '{start: 1'b1, free: 1'b1, span: r_spanb, prev: r_prevb};
                meta_re    = !r_phase && (r_b != '0);
                meta_raddr = r_prevb;
            end
            S_F_P1: begin
                if (meta_rdata.start && meta_rdata.free
                    && (GCNT_W'(r_prevb) + meta_rdata.span == GCNT_W'(r_b))) begin
                    // previous block is free: it absorbs the freed one
                    n_phase = 1'b1;
                    n_n     = r_b;
                    n_nspan = r_spanb;
                    n_b     = r_prevb;
                    n_spanb = meta_rdata.span;
                    n_prevb = meta_rdata.prev;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_g    <= n_lo_g;
        r_gcnt    <= n_gcnt;
        r_cnt     <= n_cnt;
        r_size    <= n_size;
        r_szg     <= n_szg;
        r_amask   <= n_amask;
        r_b       <= n_b;
        r_start   <= n_start;
        r_wrapped <= n_wrapped;
        r_spanb   <= n_spanb;
        r_prevb   <= n_prevb;
        r_bfree   <= n_bfree;
        r_endg    <= n_endg;
        r_u       <= n_u;
        r_lim     <= n_lim;
        r_ug      <= n_ug;
        r_sg      <= n_sg;
        r_split   <= n_split;
        r_g       <= n_g;
        r_gsize   <= n_gsize;
        r_n       <= n_n;
        r_nspan   <= n_nspan;
        r_after   <= n_after;
        r_phase   <= n_phase;
        r_query   <= n_query;
        r_status  <= n_status;
        r_raddr   <= n_raddr;
        r_rsize   <= n_rsize;
    end

    // ------------------------------------------------------ outputs
    assign busy                    = (r_state != S_IDLE);
    assign o_result_valid          = (r_state == S_RESP);
    assign o_result.status         = r_status;
    assign o_result.result_address = (r_status == ST_OK) ? r_raddr : '0;
    assign o_result.result_size    = (r_status == ST_OK) ? r_rsize : '0;

    // ------------------------------------------------------ assertions
`include "next_fit_heap_allocator_macros.svh"

    `NFHA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `NFHA_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, o_result_valid, !o_result_valid && !busy, "result strobe longer than one cycle")
    `NFHA_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, r_ready && !busy, GCNT_W'(r_cursor) < r_gcnt, "search cursor outside arena")
    `NFHA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_result_valid && r_status != ST_OK, o_result.result_address == '0 && o_result.result_size == '0, "failed item returned data")

endmodule

FILE: hdl/nfha_ram.sv
// ----------------------------------------------------------------------------
// nfha_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
